// ===== src/csl_pkg.sv =====
// Shared types, constants and keyword tables for the C subset lexer.
`timescale 1ns / 1ps
`default_nettype none

package csl_pkg;

    localparam int COORD_WIDTH     = 16;
    localparam int KEYWORD_MAX_LEN = 6;
    localparam int KW_IDX_W        = $clog2(KEYWORD_MAX_LEN);
    localparam int BYTE_W          = 8;
    localparam int KIND_W          = 5;
    localparam int NUM_W           = 31;
    localparam int LEN_W           = 8;
    localparam int PC_W            = 3;
    localparam int MAX_RESULTS     = 3;
    localparam int CNT_W           = 2;
    localparam int KW_COUNT        = 5;
    localparam int KW_TEXT_MAX     = 8;

    localparam logic [NUM_W-1:0] NUM_MAX = '1;
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    // Token kinds
    localparam logic [KIND_W-1:0] K_SEMI   = 5'd0;
    localparam logic [KIND_W-1:0] K_PLUS   = 5'd1;
    localparam logic [KIND_W-1:0] K_MINUS  = 5'd2;
    localparam logic [KIND_W-1:0] K_STAR   = 5'd3;
    localparam logic [KIND_W-1:0] K_SLASH  = 5'd4;
    localparam logic [KIND_W-1:0] K_LPAREN = 5'd5;
    localparam logic [KIND_W-1:0] K_RPAREN = 5'd6;
    localparam logic [KIND_W-1:0] K_AMP    = 5'd7;
    localparam logic [KIND_W-1:0] K_ASSIGN = 5'd8;
    localparam logic [KIND_W-1:0] K_EQEQ   = 5'd9;
    localparam logic [KIND_W-1:0] K_NE     = 5'd10;
    localparam logic [KIND_W-1:0] K_GT     = 5'd11;
    localparam logic [KIND_W-1:0] K_GE     = 5'd12;
    localparam logic [KIND_W-1:0] K_LT     = 5'd13;
    localparam logic [KIND_W-1:0] K_LE     = 5'd14;
    localparam logic [KIND_W-1:0] K_LBRACE = 5'd15;
    localparam logic [KIND_W-1:0] K_RBRACE = 5'd16;
    localparam logic [KIND_W-1:0] K_NUM    = 5'd17;
    localparam logic [KIND_W-1:0] K_IDENT  = 5'd18;
    localparam logic [KIND_W-1:0] K_RETURN = 5'd19;
    localparam logic [KIND_W-1:0] K_IF     = 5'd20;
    localparam logic [KIND_W-1:0] K_ELSE   = 5'd21;
    localparam logic [KIND_W-1:0] K_FOR    = 5'd22;
    localparam logic [KIND_W-1:0] K_WHILE  = 5'd23;
    localparam logic [KIND_W-1:0] K_END    = 5'd24;
    localparam logic [KIND_W-1:0] K_ERR    = 5'd25;

    // Pending token classes
    localparam logic [PC_W-1:0] PC_NONE = 3'd0;
    localparam logic [PC_W-1:0] PC_EQ   = 3'd1;
    localparam logic [PC_W-1:0] PC_BANG = 3'd2;
    localparam logic [PC_W-1:0] PC_LT   = 3'd3;
    localparam logic [PC_W-1:0] PC_GT   = 3'd4;
    localparam logic [PC_W-1:0] PC_NUM  = 3'd5;
    localparam logic [PC_W-1:0] PC_NAME = 3'd6;

    // Characters
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SEMI   = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [BYTE_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [BYTE_W-1:0] CH_AMP    = 8'h26;
    localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [BYTE_W-1:0] CH_EQ     = 8'h3D;
    localparam logic [BYTE_W-1:0] CH_BANG   = 8'h21;
    localparam logic [BYTE_W-1:0] CH_LT     = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_GT     = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_0      = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9      = 8'h39;
    localparam logic [BYTE_W-1:0] CH_UNDER  = 8'h5F;
    localparam logic [BYTE_W-1:0] CH_LC_A   = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LC_Z   = 8'h7A;
    localparam logic [BYTE_W-1:0] CH_UC_A   = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UC_Z   = 8'h5A;

    // Keyword table
    localparam logic [BYTE_W-1:0] KW_CHARS [KW_COUNT][KW_TEXT_MAX] = '{
        '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"f", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00}
    };
    localparam logic [LEN_W-1:0] KW_LEN [KW_COUNT] = '{8'd6, 8'd2, 8'd4, 8'd3, 8'd5};
    localparam logic [KIND_W-1:0] KW_KIND [KW_COUNT] = '{K_RETURN, K_IF, K_ELSE, K_FOR, K_WHILE};

    typedef logic [COORD_WIDTH-1:0] t_coord;
    typedef logic [KEYWORD_MAX_LEN-1:0][BYTE_W-1:0] t_prefix;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [NUM_W-1:0]  value;
        t_coord            line;
        t_coord            column;
        logic [LEN_W-1:0]  length;
    } t_token;

    typedef struct packed {
        logic   valid;
        t_token tok;
    } t_tok_opt;

    typedef struct packed {
        t_token [MAX_RESULTS-1:0] tok;
        logic [CNT_W-1:0]         cnt;
    } t_bundle;

endpackage

`default_nettype wire

// ===== src/csl_if.sv =====
// Valid/ready channel interfaces for source bytes and tokens.
`timescale 1ns / 1ps
`default_nettype none

interface csl_in_if;
    logic                       valid;
    logic                       ready;
    logic [csl_pkg::BYTE_W-1:0] source_byte;
    logic                       final_byte;

    modport source (output valid, output source_byte, output final_byte, input ready);
    modport sink (input valid, input source_byte, input final_byte, output ready);
endinterface

interface csl_out_if;
    logic                       valid;
    logic                       ready;
    logic [csl_pkg::KIND_W-1:0] kind;
    logic [csl_pkg::NUM_W-1:0]  number_value;
    csl_pkg::t_coord            token_line;
    csl_pkg::t_coord            token_column;
    logic [csl_pkg::LEN_W-1:0]  token_length;
    logic                       run_end;

    modport source (output valid, output kind, output number_value, output token_line,
                    output token_column, output token_length, output run_end, input ready);
    modport sink (input valid, input kind, input number_value, input token_line,
                  input token_column, input token_length, input run_end, output ready);
endinterface

`default_nettype wire

// ===== src/csl_scan.sv =====
// Lexer state and per-byte token generation.
`timescale 1ns / 1ps
`default_nettype none

module csl_scan (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_accept,
    input  wire logic [csl_pkg::BYTE_W-1:0] i_source_byte,
    input  wire logic                       i_final_byte,
    output csl_pkg::t_bundle                o_bundle
);

    logic [csl_pkg::PC_W-1:0]  r_pc, n_pc;
    logic [csl_pkg::NUM_W-1:0] r_acc, n_acc;
    csl_pkg::t_prefix          r_pre, n_pre;
    logic [csl_pkg::LEN_W-1:0] r_len, n_len;
    csl_pkg::t_coord           r_line, n_line;
    csl_pkg::t_coord           r_col, n_col;
    csl_pkg::t_coord           r_scol, n_scol;

    logic                        w_digit, w_letter, w_used;
    logic [csl_pkg::NUM_W+3:0]   w_mul;
    csl_pkg::t_tok_opt           w_tok_a, w_tok_b, w_tok_c, w_tok_d;
    csl_pkg::t_bundle            w_bundle;

    function automatic logic [csl_pkg::KIND_W-1:0] f_name_kind(
        input csl_pkg::t_prefix          pre,
        input logic [csl_pkg::LEN_W-1:0] len
    );
        logic [csl_pkg::KIND_W-1:0] kind;
        logic                       hit;
        kind = csl_pkg::K_IDENT;
        for (int w = 0; w < csl_pkg::KW_COUNT; w++) begin
            hit = (len == csl_pkg::KW_LEN[w]);
            for (int i = 0; i < csl_pkg::KEYWORD_MAX_LEN; i++) begin
                if ((csl_pkg::LEN_W'(i) < csl_pkg::KW_LEN[w]) &&
                    (pre[i] != csl_pkg::KW_CHARS[w][i])) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                kind = csl_pkg::KW_KIND[w];
            end
        end
        return kind;
    endfunction

    // Token for a pending item that the next byte does not continue.
    function automatic csl_pkg::t_tok_opt f_close(
        input logic [csl_pkg::PC_W-1:0]  pc,
        input logic [csl_pkg::NUM_W-1:0] acc,
        input csl_pkg::t_prefix          pre,
        input logic [csl_pkg::LEN_W-1:0] len,
        input csl_pkg::t_coord           scol,
        input csl_pkg::t_coord           line
    );
        csl_pkg::t_tok_opt t;
        t.valid      = 1'b1;
        t.tok.value  = '0;
        t.tok.line   = line;
        t.tok.column = scol;
        t.tok.length = csl_pkg::LEN_W'(1);
        unique case (pc)
            csl_pkg::PC_EQ:   t.tok.kind = csl_pkg::K_ASSIGN;
            csl_pkg::PC_BANG: t.tok.kind = csl_pkg::K_ERR;
            csl_pkg::PC_LT:   t.tok.kind = csl_pkg::K_LT;
            csl_pkg::PC_GT:   t.tok.kind = csl_pkg::K_GT;
            csl_pkg::PC_NUM: begin
                t.tok.kind   = csl_pkg::K_NUM;
                t.tok.value  = acc;
                t.tok.length = len;
            end
            csl_pkg::PC_NAME: begin
                t.tok.kind   = f_name_kind(pre, len);
                t.tok.length = len;
            end
            default: begin
                t.valid    = 1'b0;
                t.tok.kind = csl_pkg::K_ERR;
            end
        endcase
        return t;
    endfunction

    function automatic logic [csl_pkg::KIND_W-1:0] f_two_kind(
        input logic [csl_pkg::PC_W-1:0] pc
    );
        logic [csl_pkg::KIND_W-1:0] kind;
        unique case (pc)
            csl_pkg::PC_EQ:   kind = csl_pkg::K_EQEQ;
            csl_pkg::PC_BANG: kind = csl_pkg::K_NE;
            csl_pkg::PC_LT:   kind = csl_pkg::K_LE;
            default:          kind = csl_pkg::K_GE;
        endcase
        return kind;
    endfunction

    function automatic csl_pkg::t_tok_opt f_one(
        input logic [csl_pkg::KIND_W-1:0] kind,
        input csl_pkg::t_coord            line,
        input csl_pkg::t_coord            col
    );
        csl_pkg::t_tok_opt t;
        t.valid      = 1'b1;
        t.tok.kind   = kind;
        t.tok.value  = '0;
        t.tok.line   = line;
        t.tok.column = col;
        t.tok.length = csl_pkg::LEN_W'(1);
        return t;
    endfunction

    assign w_digit  = (i_source_byte >= csl_pkg::CH_0) && (i_source_byte <= csl_pkg::CH_9);
    assign w_letter = ((i_source_byte >= csl_pkg::CH_LC_A) && (i_source_byte <= csl_pkg::CH_LC_Z))
                   || ((i_source_byte >= csl_pkg::CH_UC_A) && (i_source_byte <= csl_pkg::CH_UC_Z));

    // acc * 10 + digit
    assign w_mul = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                 + {(csl_pkg::NUM_W)'(0), i_source_byte[3:0]};

    always_comb begin
        n_pc    = r_pc;
        n_acc   = r_acc;
        n_pre   = r_pre;
        n_len   = r_len;
        n_line  = r_line;
        n_col   = r_col;
        n_scol  = r_scol;
        w_used  = 1'b0;
        w_tok_a = '0;
        w_tok_b = '0;
        w_tok_c = '0;
        w_tok_d = '0;

        // continue or close the pending item
        case (r_pc) inside
            csl_pkg::PC_EQ, csl_pkg::PC_BANG, csl_pkg::PC_LT, csl_pkg::PC_GT: begin
                if (i_source_byte == csl_pkg::CH_EQ) begin
                    w_tok_a            = f_one(f_two_kind(r_pc), r_line, r_scol);
                    w_tok_a.tok.length = csl_pkg::LEN_W'(2);
                    w_used             = 1'b1;
                end else begin
                    w_tok_a = f_close(r_pc, r_acc, r_pre, r_len, r_scol, r_line);
                end
                n_pc = csl_pkg::PC_NONE;
            end
            csl_pkg::PC_NUM: begin
                if (w_digit) begin
                    n_acc  = (w_mul > {4'b0000, csl_pkg::NUM_MAX}) ? csl_pkg::NUM_MAX
                                                                   : w_mul[csl_pkg::NUM_W-1:0];
                    n_len  = (r_len != csl_pkg::LEN_MAX) ? r_len + csl_pkg::LEN_W'(1) : r_len;
                    w_used = 1'b1;
                end else begin
                    w_tok_a = f_close(r_pc, r_acc, r_pre, r_len, r_scol, r_line);
                    n_pc    = csl_pkg::PC_NONE;
                end
            end
            csl_pkg::PC_NAME: begin
                if (w_digit || w_letter || (i_source_byte == csl_pkg::CH_UNDER)) begin
                    if (r_len < csl_pkg::LEN_W'(csl_pkg::KEYWORD_MAX_LEN)) begin
                        n_pre[r_len[csl_pkg::KW_IDX_W-1:0]] = i_source_byte;
                    end
                    n_len  = (r_len != csl_pkg::LEN_MAX) ? r_len + csl_pkg::LEN_W'(1) : r_len;
                    w_used = 1'b1;
                end else begin
                    w_tok_a = f_close(r_pc, r_acc, r_pre, r_len, r_scol, r_line);
                    n_pc    = csl_pkg::PC_NONE;
                end
            end
            default: n_pc = csl_pkg::PC_NONE;
        endcase

        // byte not consumed by a pending item starts something new
        if (!w_used) begin
            case (i_source_byte) inside
                csl_pkg::CH_SPACE, csl_pkg::CH_NL: begin
                end
                csl_pkg::CH_SEMI:   w_tok_b = f_one(csl_pkg::K_SEMI, r_line, r_col);
                csl_pkg::CH_PLUS:   w_tok_b = f_one(csl_pkg::K_PLUS, r_line, r_col);
                csl_pkg::CH_MINUS:  w_tok_b = f_one(csl_pkg::K_MINUS, r_line, r_col);
                csl_pkg::CH_STAR:   w_tok_b = f_one(csl_pkg::K_STAR, r_line, r_col);
                csl_pkg::CH_SLASH:  w_tok_b = f_one(csl_pkg::K_SLASH, r_line, r_col);
                csl_pkg::CH_LPAREN: w_tok_b = f_one(csl_pkg::K_LPAREN, r_line, r_col);
                csl_pkg::CH_RPAREN: w_tok_b = f_one(csl_pkg::K_RPAREN, r_line, r_col);
                csl_pkg::CH_AMP:    w_tok_b = f_one(csl_pkg::K_AMP, r_line, r_col);
                csl_pkg::CH_LBRACE: w_tok_b = f_one(csl_pkg::K_LBRACE, r_line, r_col);
                csl_pkg::CH_RBRACE: w_tok_b = f_one(csl_pkg::K_RBRACE, r_line, r_col);
                csl_pkg::CH_EQ: begin
                    n_pc   = csl_pkg::PC_EQ;
                    n_scol = r_col;
                end
                csl_pkg::CH_BANG: begin
                    n_pc   = csl_pkg::PC_BANG;
                    n_scol = r_col;
                end
                csl_pkg::CH_LT: begin
                    n_pc   = csl_pkg::PC_LT;
                    n_scol = r_col;
                end
                csl_pkg::CH_GT: begin
                    n_pc   = csl_pkg::PC_GT;
                    n_scol = r_col;
                end
                default: begin
                    if (w_digit) begin
                        n_pc   = csl_pkg::PC_NUM;
                        n_scol = r_col;
                        n_acc  = {(csl_pkg::NUM_W-4)'(0), i_source_byte[3:0]};
                        n_len  = csl_pkg::LEN_W'(1);
                    end else if (w_letter) begin
                        n_pc     = csl_pkg::PC_NAME;
                        n_scol   = r_col;
                        n_pre[0] = i_source_byte;
                        n_len    = csl_pkg::LEN_W'(1);
                    end else begin
                        w_tok_b = f_one(csl_pkg::K_ERR, r_line, r_col);
                    end
                end
            endcase
        end

        if (i_source_byte == csl_pkg::CH_NL) begin
            n_line = r_line + csl_pkg::COORD_WIDTH'(1);
            n_col  = '0;
        end else begin
            n_col = r_col + csl_pkg::COORD_WIDTH'(1);
        end

        // end of text: flush, end token, back to reset state
        if (i_final_byte) begin
            w_tok_c = f_close(n_pc, n_acc, n_pre, n_len, n_scol, n_line);
            w_tok_d = f_one(csl_pkg::K_END, n_line, n_col);
            w_tok_d.tok.length = '0;
            n_pc   = csl_pkg::PC_NONE;
            n_acc  = '0;
            n_len  = '0;
            n_line = '0;
            n_col  = '0;
            n_scol = '0;
        end
    end

    // pack the produced tokens in order
    always_comb begin
        w_bundle = '0;
        if (w_tok_a.valid) begin
            w_bundle.tok[w_bundle.cnt] = w_tok_a.tok;
            w_bundle.cnt               = w_bundle.cnt + csl_pkg::CNT_W'(1);
        end
        if (w_tok_b.valid) begin
            w_bundle.tok[w_bundle.cnt] = w_tok_b.tok;
            w_bundle.cnt               = w_bundle.cnt + csl_pkg::CNT_W'(1);
        end
        if (w_tok_c.valid) begin
            w_bundle.tok[w_bundle.cnt] = w_tok_c.tok;
            w_bundle.cnt               = w_bundle.cnt + csl_pkg::CNT_W'(1);
        end
        if (w_tok_d.valid) begin
            w_bundle.tok[w_bundle.cnt] = w_tok_d.tok;
            w_bundle.cnt               = w_bundle.cnt + csl_pkg::CNT_W'(1);
        end
    end

    assign o_bundle = w_bundle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= csl_pkg::PC_NONE;
            r_acc  <= '0;
            r_len  <= '0;
            r_line <= '0;
            r_col  <= '0;
            r_scol <= '0;
        end else if (i_accept) begin
            r_pc   <= n_pc;
            r_acc  <= n_acc;
            r_len  <= n_len;
            r_line <= n_line;
            r_col  <= n_col;
            r_scol <= n_scol;
        end
    end

    // name prefix: only entries written by the current name are ever read
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_pre <= n_pre;
        end
    end

endmodule

`default_nettype wire

// ===== src/c_subset_lexer.sv =====
// Top level of the streaming C subset lexer.
//
// Channels: i_src takes one source byte per item, with final_byte set on the
// last byte of a text. o_tok gives one token per item: kind, number value,
// start line and column, length, and run_end on the last token a byte caused.
// A byte causes zero to three tokens; the final byte flushes any pending
// token and appends an end token, after which the lexer starts a new text.
//
// Latency: a byte's first token appears on o_tok the cycle after it is taken.
// Throughput: one byte per cycle while o_tok is not stalled and each byte
// yields at most one token. A byte yielding more holds the result buffer
// until its last token leaves, since o_tok moves one token per ready cycle;
// bytes yielding no token update the lexer state but never mark it valid.
//
// The result buffer separates the two sides: a new byte is taken in the
// same cycle that the last token of the previous byte leaves. When o_tok is
// stalled the buffered token holds and i_src.ready drops.
//
// Reset (synchronous, active low) empties the buffer and returns the line,
// column and pending token to their start values.
`timescale 1ns / 1ps
`default_nettype none

module c_subset_lexer (
    input wire logic   i_clk,
    input wire logic   i_rst_n,
    csl_in_if.sink     i_src,
    csl_out_if.source  o_tok
);

    csl_pkg::t_bundle                            w_bundle;
    logic                                        w_accept;
    logic                                        w_last;
    csl_pkg::t_token                             w_cur;

    csl_pkg::t_token [csl_pkg::MAX_RESULTS-1:0]  r_tok;
    logic [csl_pkg::CNT_W-1:0]                   r_cnt;
    logic [csl_pkg::CNT_W-1:0]                   r_idx;
    logic                                        r_bv;

    assign w_accept    = i_src.valid && i_src.ready;
    assign w_last      = (r_idx == (r_cnt - csl_pkg::CNT_W'(1)));
    // free when empty or when the last buffered token leaves this cycle
    assign i_src.ready = !r_bv || (o_tok.ready && w_last);

    csl_scan u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_source_byte (i_src.source_byte),
        .i_final_byte  (i_src.final_byte),
        .o_bundle      (w_bundle)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv  <= 1'b0;
            r_idx <= '0;
            r_cnt <= '0;
        end else begin
            if (r_bv && o_tok.ready) begin
                if (w_last) begin
                    r_bv <= 1'b0;
                end else begin
                    r_idx <= r_idx + csl_pkg::CNT_W'(1);
                end
            end
            if (w_accept && (w_bundle.cnt != '0)) begin
                r_bv  <= 1'b1;
                r_idx <= '0;
                r_cnt <= w_bundle.cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_tok <= w_bundle.tok;
        end
    end

    assign w_cur = r_tok[r_idx];

    assign o_tok.valid        = r_bv;
    assign o_tok.kind         = w_cur.kind;
    assign o_tok.number_value = w_cur.value;
    assign o_tok.token_line   = w_cur.line;
    assign o_tok.token_column = w_cur.column;
    assign o_tok.token_length = w_cur.length;
    assign o_tok.run_end      = w_last;

endmodule

`default_nettype wire

// ===== src/csl_checker.sv =====
// Port-level assertions for the lexer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module csl_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_ready,
    input wire logic                       i_out_valid,
    input wire logic                       i_out_ready,
    input wire logic [csl_pkg::KIND_W-1:0] i_kind,
    input wire logic [csl_pkg::NUM_W-1:0]  i_number_value,
    input wire logic [csl_pkg::LEN_W-1:0]  i_token_length,
    input wire logic                       i_run_end
);

    // stalled token holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_kind)
            && $stable(i_number_value) && $stable(i_token_length))
        else $error("stalled token changed");

    // no new byte while the buffered token is stuck
    a_stall_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("byte taken during output stall");

    // end token is the last of its byte and has no length
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind == csl_pkg::K_END) |-> i_run_end && (i_token_length == '0))
        else $error("end token malformed");

    a_value_only_num: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind != csl_pkg::K_NUM) |-> (i_number_value == '0))
        else $error("value on non-number token");

    a_num_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind == csl_pkg::K_NUM) |-> (i_token_length != '0))
        else $error("number token with zero length");

endmodule

bind c_subset_lexer csl_checker u_csl_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_src.ready),
    .i_out_valid    (o_tok.valid),
    .i_out_ready    (o_tok.ready),
    .i_kind         (o_tok.kind),
    .i_number_value (o_tok.number_value),
    .i_token_length (o_tok.token_length),
    .i_run_end      (o_tok.run_end)
);

`default_nettype wire
